// ===== rtl/itoa_pkg.sv =====
`default_nettype none

package itoa_pkg;

    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [DIGIT_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [DIGIT_W-1:0] RADIX_MAX = 6'd35;
    localparam logic [DIGIT_W-1:0] RADIX_RST = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    // 'a' minus ten, so that digit ten maps to 'a'
    localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h57;

    // Shift control shared by every cell of the digit stack
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] dc;
        dc = (d > RADIX_MAX) ? RADIX_MAX : d;
        if (dc < 6'd10) begin
            return CHAR_ZERO + {2'b00, dc};
        end else begin
            return CHAR_ALPHA + {2'b00, dc};
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/itoa_digit_cell.sv =====
`default_nettype none

module itoa_digit_cell (
    input  wire                           i_clk,
    input  itoa_pkg::t_cell_ctl           i_ctl,
    input  wire [itoa_pkg::DIGIT_W-1:0]   i_from_lo,
    input  wire [itoa_pkg::DIGIT_W-1:0]   i_from_hi,
    output logic [itoa_pkg::DIGIT_W-1:0]  o_digit
);
    import itoa_pkg::*;

    logic [DIGIT_W-1:0] r_digit;

    // Push takes the neighbor nearer the top, pop the one deeper down
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_digit <= i_from_lo;
        end else if (i_ctl.pop) begin
            r_digit <= i_from_hi;
        end
    end

    assign o_digit = r_digit;

endmodule

`default_nettype wire

// ===== rtl/itoa_divider.sv =====
`default_nettype none

module itoa_divider #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire [VALUE_WIDTH-1:0]         i_dividend,
    input  wire [itoa_pkg::DIGIT_W-1:0]   i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [VALUE_WIDTH-1:0]        o_quotient,
    output logic [itoa_pkg::DIGIT_W-1:0]  o_remainder
);
    import itoa_pkg::*;

    localparam int CNT_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [DIGIT_W-1:0]     r_rem;
    logic [DIGIT_W-1:0]     r_div;

    logic [DIGIT_W:0]       trial;
    logic [DIGIT_W:0]       diff;
    logic                   q_bit;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, r_div};
        q_bit = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(VALUE_WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[VALUE_WIDTH-2:0], q_bit};
            r_rem <= q_bit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== rtl/int_to_ascii_radix_core.sv =====
`default_nettype none

// Integer to ASCII text in a programmable base.
//
// Input channel: i_valid / o_stall carry one signed i_number per beat. The
// block takes one number at a time; o_stall is low only while it is idle.
// Output channel: o_valid / i_stall carry one character per beat: a '-' for a
// negative number, the digits most significant first (0-9 then a-y), and a
// NUL terminator with o_last set. A base outside 2..35 gives the NUL alone.
// Config: i_radix_we writes i_radix (the base); write only while idle.
//
// Operation: each digit comes from the shared bit-serial divider; digits are then
// popped from the cell row one character a cycle while the output is not stalled.
// A stall on the output simply holds the output register and the cell row;
// nothing is dropped. The next number is taken as soon as the terminator is
// loaded into the output register.
// Reset (synchronous, active low) returns to idle, empties the output and
// sets the base to ten.
module int_to_ascii_radix_core #(
    parameter int VALUE_WIDTH = 16,
    parameter int MAX_DIGITS  = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // number in
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire signed [VALUE_WIDTH-1:0]        i_number,
    // characters out
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic [itoa_pkg::CHAR_W-1:0]         o_char_code,
    output logic                                o_last,
    // base register
    input  wire                                 i_radix_we,
    input  wire [itoa_pkg::DIGIT_W-1:0]         i_radix
);
    import itoa_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_SIGN  = 5'b00100,
        S_DIGIT = 5'b01000,
        S_TERM  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [DIGIT_W-1:0]      r_radix;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_neg, n_neg;

    logic                    r_o_valid, n_o_valid;
    logic [CHAR_W-1:0]       r_char, n_char;
    logic                    r_last, n_last;

    // divider hookup
    logic                    div_start;
    logic [VALUE_WIDTH-1:0]  div_dividend;
    logic                    div_busy;
    logic                    div_done;
    logic [VALUE_WIDTH-1:0]  div_quo;
    logic [DIGIT_W-1:0]      div_rem;

    // digit stack
    t_cell_ctl               cell_ctl;
    logic [DIGIT_W-1:0]      cell_q [MAX_DIGITS];

    logic                    in_beat;
    logic                    out_free;
    logic                    radix_ok;
    logic [VALUE_WIDTH-1:0]  magnitude;
    logic [CNT_W-1:0]        count_inc;

    assign o_stall   = (r_state != S_IDLE);
    assign in_beat   = i_valid && !o_stall;
    assign out_free  = !r_o_valid || !i_stall;
    assign radix_ok  = (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX);
    // Two's complement negate; the most negative value lands on 2^(W-1) unsigned
    assign magnitude = i_number[VALUE_WIDTH-1] ?
                       ({VALUE_WIDTH{1'b0}} - $unsigned(i_number)) : $unsigned(i_number);
    assign count_inc = r_count + 1'b1;

    // Base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RST;
        end else if (i_radix_we) begin
            r_radix <= i_radix;
        end
    end

    // Sequencer: divide digits into the stack, then send the sign, pop the digits out in order and send the terminator
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_neg        = r_neg;
        n_o_valid    = r_o_valid && i_stall;
        n_char       = r_char;
        n_last       = r_last;
        div_start    = 1'b0;
        div_dividend = magnitude;
        cell_ctl     = '{push: 1'b0, pop: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (in_beat) begin
                    n_count = '0;
                    if (radix_ok) begin
                        n_neg     = i_number[VALUE_WIDTH-1];
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end else begin
                        n_state = S_TERM;
                    end
                end
            end
            S_DIV: begin
                div_dividend = div_quo;
                if (div_done) begin
                    cell_ctl.push = 1'b1;
                    n_count       = count_inc;
                    if ((div_quo != '0) && (count_inc != CNT_W'(MAX_DIGITS))) begin
                        div_start = 1'b1;
                    end else begin
                        n_state = r_neg ? S_SIGN : S_DIGIT;
                    end
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_char    = CHAR_MINUS;
                    n_last    = 1'b0;
                    n_state   = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (out_free) begin
                    n_o_valid    = 1'b1;
                    n_char       = digit_char(cell_q[0]);
                    n_last       = 1'b0;
                    cell_ctl.pop = 1'b1;
                    n_count      = r_count - 1'b1;
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_TERM;
                    end
                end
            end
            S_TERM: begin
                if (out_free) begin
                    n_o_valid = 1'b1;
                    n_char    = CHAR_NUL;
                    n_last    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_neg     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_neg     <= n_neg;
            r_o_valid <= n_o_valid;
        end
    end

    // Output payload: hold while stalled
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid     = r_o_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;

    itoa_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (r_radix),
        .o_busy      (div_busy),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // Stack of digit cells; cell 0 is the top. Push enters at cell 0 and
    // shifts the row deeper, pop shifts it back toward cell 0.
    for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_cell
        logic [DIGIT_W-1:0] from_lo;
        logic [DIGIT_W-1:0] from_hi;

        if (g == 0) begin : g_top
            assign from_lo = div_rem;
        end else begin : g_mid
            assign from_lo = cell_q[g-1];
        end

        if (g == MAX_DIGITS - 1) begin : g_bottom
            assign from_hi = '0;
        end else begin : g_inner
            assign from_hi = cell_q[g+1];
        end

        itoa_digit_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (cell_ctl),
            .i_from_lo (from_lo),
            .i_from_hi (from_hi),
            .o_digit   (cell_q[g])
        );
    end

    // The terminator is the only character that carries the last flag
    a_last_is_nul : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_char_code == CHAR_NUL)
        else $error("last flag on a non-terminator character");

    // Stack depth never exceeds the cell count
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DIGITS))
        else $error("digit count beyond stack depth");

    // Popping digits only with digits held
    a_digit_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIGIT |-> r_count != '0)
        else $error("digit emission with an empty stack");

    // Divider is only started when it is free
    a_div_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire
